[rtl/core/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, codes and types of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KeyW          = 32;
  localparam int ValueW        = 32;
  localparam int CapW          = 5;
  localparam int MaxEntriesDef = 16;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_HIT,
    MODE_FILL,
    MODE_EVICT
  } lkvc_mode_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } lkvc_entry_t;

  typedef struct packed {
    logic       clear;
    logic       probe;
    logic       commit;
    lkvc_mode_e mode;
  } lkvc_ctrl_t;

endpackage

[rtl/core/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency slot: holds an entry, compares it, and shifts from its neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lkvc_pkg::lkvc_ctrl_t             ctrl_i,
  input  logic [lkvc_pkg::KeyW-1:0]        probe_key_i,
  input  lkvc_pkg::lkvc_entry_t            prev_entry_i,
  input  logic                             prev_valid_i,
  input  logic                             match_i,
  input  logic [lkvc_pkg::ValueW-1:0]      hit_value_i,
  output lkvc_pkg::lkvc_entry_t            entry_o,
  output logic                             valid_o,
  output logic                             match_o,
  output logic [lkvc_pkg::ValueW-1:0]      hit_value_o
);

  lkvc_pkg::lkvc_entry_t entry_q;
  logic                  valid_q;
  logic                  match_q;
  logic                  shift;

  assign match_o     = match_q | match_i;
  assign hit_value_o = (match_q ? entry_q.value : '0) | hit_value_i;
  assign entry_o     = entry_q;
  assign valid_o     = valid_q;

  always_comb begin
    unique case (ctrl_i.mode)
      lkvc_pkg::MODE_HIT:   shift = match_o;
      lkvc_pkg::MODE_FILL:  shift = prev_valid_i;
      lkvc_pkg::MODE_EVICT: shift = valid_q;
      default:              shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.probe) begin
        match_q <= valid_q && (entry_q.key == probe_key_i);
      end
      if (ctrl_i.commit && shift) begin
        valid_q <= prev_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && shift) begin
      entry_q <= prev_entry_i;
    end
  end

endmodule

[rtl/core/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// In the accept cycle every cell compares its key with the item key; at commit
// the match and hit value ripple along the cell row and the row shifts by one
// behind the new most recent entry. The result lands in an output register;
// while it waits, the next item is still accepted and holds, uncommitted,
// until the register is free. The store is empty after reset and after every
// capacity write, which clears all cell valid bits directly.
module lru_key_value_cache_unit #(
  parameter int MaxEntries = lkvc_pkg::MaxEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]     cfg_wdata_i,     // capacity_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,    // key, write_value
  input  logic                          s_axis_tuser,    // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,    // read_value
  output logic                          m_axis_tuser     // found
);

  localparam int CntW = $clog2(MaxEntries + 1);

  logic                               busy_q;
  logic                               op_q;
  logic [lkvc_pkg::KeyW-1:0]          key_q;
  logic [lkvc_pkg::ValueW-1:0]        wval_q;
  logic [lkvc_pkg::CapW-1:0]          cap_q;
  logic [CntW-1:0]                    count_q;
  logic                               out_valid_q;
  logic                               out_found_q;
  logic [lkvc_pkg::ValueW-1:0]        out_value_q;

  logic                               accept;
  logic                               commit;
  logic                               hit;
  logic                               full;
  lkvc_pkg::lkvc_ctrl_t               ctrl;
  lkvc_pkg::lkvc_entry_t              head;
  lkvc_pkg::lkvc_entry_t              cell_entry [MaxEntries];
  logic [MaxEntries-1:0]              cell_valid;
  logic [MaxEntries:0]                match_chain;
  logic [lkvc_pkg::ValueW-1:0]        value_chain [MaxEntries+1];

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = busy_q && (!out_valid_q || m_axis_tready);
  assign hit           = match_chain[0];
  assign full          = (count_q != '0) &&
                         ((32'(count_q) >= 32'(cap_q)) || (32'(count_q) == MaxEntries));

  always_comb begin
    ctrl.clear  = cfg_we_i;
    ctrl.probe  = accept;
    ctrl.commit = commit;
    priority if (hit) begin
      ctrl.mode = lkvc_pkg::MODE_HIT;
    end else if (op_q == lkvc_pkg::OpPut) begin
      ctrl.mode = full ? lkvc_pkg::MODE_EVICT : lkvc_pkg::MODE_FILL;
    end else begin
      ctrl.mode = lkvc_pkg::MODE_NONE;
    end
  end

  assign head.key   = key_q;
  assign head.value = (op_q == lkvc_pkg::OpPut) ? wval_q : value_chain[0];

  assign match_chain[MaxEntries] = 1'b0;
  assign value_chain[MaxEntries] = '0;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    lkvc_pkg::lkvc_entry_t prev_entry;
    logic                  prev_valid;
    if (i == 0) begin : g_head
      assign prev_entry = head;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_entry = cell_entry[i-1];
      assign prev_valid = cell_valid[i-1];
    end
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .probe_key_i  (s_axis_tdata[31:0]),
      .prev_entry_i (prev_entry),
      .prev_valid_i (prev_valid),
      .match_i      (match_chain[i+1]),
      .hit_value_i  (value_chain[i+1]),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (match_chain[i]),
      .hit_value_o  (value_chain[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cap_q       <= lkvc_pkg::CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        count_q <= '0;
      end else if (commit && ctrl.mode == lkvc_pkg::MODE_FILL) begin
        count_q <= count_q + CntW'(1);
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      wval_q <= s_axis_tdata[63:32];
    end
    if (commit) begin
      out_found_q <= hit;
      out_value_q <= (hit && op_q == lkvc_pkg::OpGet) ? value_chain[0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_found_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MaxEntries)
    else $error("entry count above store size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid && !busy_q)
    else $error("committed item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !cfg_we_i && ctrl.mode == lkvc_pkg::MODE_FILL) |=>
      count_q == $past(count_q) + CntW'(1))
    else $error("fill did not advance entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !s_axis_tready)
    else $error("accepted item not held for lookup");
`endif

endmodule

[tb/tb_lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Self-checking bench for the LRU key-value cache: a shadow copy of the store
// (keys, values, recency order, capacity) predicts found/read_value for every
// accepted get or put, and each returned item is compared in order. Directed
// items cover extreme keys, updates, zero capacity and eviction order; random
// items follow under several capacities, one of them above the store size,
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;

  typedef logic [lkvc_pkg::CapW-1:0] cap_t;

  typedef struct packed {
    logic                        found;
    logic [lkvc_pkg::ValueW-1:0] value;
  } lookup_t;

  class lru_cache_shadow;
    logic [lkvc_pkg::KeyW-1:0]   keys[lkvc_pkg::MaxEntriesDef];
    logic [lkvc_pkg::ValueW-1:0] values[lkvc_pkg::MaxEntriesDef];
    bit                          live[lkvc_pkg::MaxEntriesDef];
    int unsigned                 rank[lkvc_pkg::MaxEntriesDef];
    int unsigned                 count;
    cap_t                        capacity;
    lookup_t                     expected_q[$];
    int unsigned                 mismatches;

    function new();
      mismatches = 0;
      set_capacity(lkvc_pkg::CapReset);
    endfunction

    function void set_capacity(cap_t c);
      capacity = c;
      foreach (live[i]) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      count = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void promote(int idx);
      int unsigned old;
      old = rank[idx];
      foreach (live[i]) begin
        if (live[i] && rank[i] < old) rank[i]++;
      end
      rank[idx] = 0;
    endfunction

    function void note_request(logic op, logic [lkvc_pkg::KeyW-1:0] key,
                               logic [lkvc_pkg::ValueW-1:0] wval);
      int          hit;
      int          slot;
      int unsigned worst;
      int unsigned eff;
      lookup_t     r;
      hit  = -1;
      slot = -1;
      worst = 0;
      foreach (live[i]) begin
        if (hit < 0 && live[i] && keys[i] == key) hit = i;
      end
      r.found = (hit >= 0);
      r.value = '0;
      if (op == lkvc_pkg::OpGet) begin
        if (hit >= 0) begin
          r.value = values[hit];
          promote(hit);
        end
      end else if (hit >= 0) begin
        values[hit] = wval;
        promote(hit);
      end else begin
        eff = (capacity == 0) ? 1 :
              ((capacity > lkvc_pkg::MaxEntriesDef) ? lkvc_pkg::MaxEntriesDef : capacity);
        if (count >= eff) begin
          foreach (live[i]) begin
            if (live[i] && (slot < 0 || rank[i] > worst)) begin
              worst = rank[i];
              slot  = i;
            end
          end
          if (slot >= 0) promote(slot);
        end else begin
          foreach (live[i]) begin
            if (slot < 0 && !live[i]) slot = i;
          end
          if (slot >= 0) begin
            foreach (live[i]) begin
              if (live[i]) rank[i]++;
            end
            live[slot] = 1'b1;
            rank[slot] = 0;
            count++;
          end
        end
        if (slot >= 0) begin
          keys[slot]   = key;
          values[slot] = wval;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_response(logic found, logic [lkvc_pkg::ValueW-1:0] value);
      lookup_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: found=%0b read_value=%08h", found, value);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0b, actual %0b", e.found, found);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("read_value: expected %08h, actual %08h", e.value, value);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  cap_t              cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = lkvc_pkg::OpGet;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              m_axis_tuser;

  lru_cache_shadow shadow = new();

  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  lru_key_value_cache_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) shadow.check_response(m_axis_tuser, m_axis_tdata);
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = 90;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(logic op, logic [lkvc_pkg::KeyW-1:0] key,
                           logic [lkvc_pkg::ValueW-1:0] wval);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wval, key};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(op, key, wval);
  endtask

  task automatic idle_for(int unsigned n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= {$urandom, $urandom};
    s_axis_tuser  <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(cap_t c);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    shadow.set_capacity(c);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= cap_t'($urandom);
    @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned items, int unsigned pool_n, bit with_hold);
    logic [lkvc_pkg::KeyW-1:0] pool[$];
    int unsigned               burst_left;
    logic                      op;
    logic [lkvc_pkg::KeyW-1:0] key;
    pool = {};
    repeat (pool_n) pool.push_back($urandom);
    if (pool_n > 3) begin
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
    end
    burst_left = 0;
    for (int unsigned n = 0; n < items; n++) begin
      if (n == items / 2) begin
        if (with_hold) hold_asked++;
        else drain();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      end
      burst_left--;
      op  = 1'($urandom_range(0, 1));
      key = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
      send_item(op, key, $urandom);
    end
    drain();
  endtask

  initial begin
    cap_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(lkvc_pkg::OpGet, 32'h8000_0000, 32'h0000_0001);
    send_item(lkvc_pkg::OpPut, 32'h8000_0000, 32'h7fff_ffff);
    send_item(lkvc_pkg::OpPut, 32'h7fff_ffff, 32'h8000_0000);
    send_item(lkvc_pkg::OpPut, 32'h0000_0000, 32'h0000_0000);
    send_item(lkvc_pkg::OpPut, 32'hffff_ffff, 32'hffff_ffff);
    send_item(lkvc_pkg::OpGet, 32'h8000_0000, 32'h0000_0000);
    send_item(lkvc_pkg::OpGet, 32'h7fff_ffff, 32'ha5a5_a5a5);
    send_item(lkvc_pkg::OpGet, 32'hffff_ffff, 32'h0000_0000);
    send_item(lkvc_pkg::OpGet, 32'h0000_0000, 32'hffff_ffff);
    send_item(lkvc_pkg::OpPut, 32'h0000_0000, 32'h1234_5678);
    send_item(lkvc_pkg::OpGet, 32'h0000_0000, 32'h0000_0000);
    send_item(lkvc_pkg::OpGet, 32'h0000_0001, 32'h0000_0000);
    drain();

    write_capacity(5'd0);
    send_item(lkvc_pkg::OpPut, 32'h0000_0001, 32'h0000_000a);
    send_item(lkvc_pkg::OpPut, 32'h0000_0002, 32'h0000_0014);
    send_item(lkvc_pkg::OpGet, 32'h0000_0001, 32'h0000_0000);
    send_item(lkvc_pkg::OpGet, 32'h0000_0002, 32'h0000_0000);
    send_item(lkvc_pkg::OpPut, 32'h0000_0002, 32'h0000_0015);
    send_item(lkvc_pkg::OpGet, 32'h0000_0002, 32'h0000_0000);
    drain();

    write_capacity(5'd2);
    send_item(lkvc_pkg::OpPut, 32'h0000_0001, 32'h0000_0011);
    send_item(lkvc_pkg::OpPut, 32'h0000_0002, 32'h0000_0022);
    send_item(lkvc_pkg::OpGet, 32'h0000_0001, 32'h0000_0000);
    send_item(lkvc_pkg::OpPut, 32'h0000_0003, 32'h0000_0033);
    send_item(lkvc_pkg::OpGet, 32'h0000_0002, 32'h0000_0000);
    send_item(lkvc_pkg::OpGet, 32'h0000_0001, 32'h0000_0000);
    drain();

    write_capacity(5'd16);
    run_phase(200, 22, 1'b1);
    write_capacity(5'd1);
    run_phase(150, 3, 1'b0);
    write_capacity(5'd31);
    run_phase(200, 24, 1'b1);
    write_capacity(5'd5);
    run_phase(200, 8, 1'b0);
    write_capacity(5'd0);
    run_phase(100, 3, 1'b0);
    repeat (4) begin
      c = cap_t'($urandom_range(0, 31));
      write_capacity(c);
      run_phase(160, ((c == 0) ? 1 : ((c > 16) ? 16 : c)) + $urandom_range(2, 6),
                1'($urandom_range(0, 1)));
    end

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_unit.sv
tb/tb_lru_key_value_cache_unit.sv
